// ===== hdl/dmwsm_pkg.sv =====
package dmwsm_pkg;

    localparam int SPEED_W    = 16;
    localparam int TICK_W     = 4;
    localparam int PROD_W     = 36;
    localparam int MUL_STEPS  = 16;
    localparam int DIV_STEPS  = 36;
    localparam int CNT_W      = 6;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [SPEED_W-1:0] FAST_DIVISOR = 16'd100;
    localparam logic [SPEED_W-1:0] SAT_MAX      = 16'hFFFF;

    localparam logic [2:0] REG_WINDOW_LEFT  = 3'd0;
    localparam logic [2:0] REG_WINDOW_RIGHT = 3'd1;
    localparam logic [2:0] REG_MODE_HOLD    = 3'd2;
    localparam logic [2:0] REG_SLOW_THRESH  = 3'd3;
    localparam logic [2:0] REG_GAIN_LEFT    = 3'd4;
    localparam logic [2:0] REG_GAIN_RIGHT   = 3'd5;

    typedef struct packed {
        logic edge_left;
        logic edge_right;
    } t_in_word;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_left;
        logic [SPEED_W-1:0] speed_right;
        logic [SPEED_W-1:0] speed_mean;
        logic               fast_left;
        logic               fast_right;
        logic               new_left;
        logic               new_right;
    } t_out_word;

    typedef struct packed {
        logic [SPEED_W-1:0] window_left_ms;
        logic [SPEED_W-1:0] window_right_ms;
        logic [SPEED_W-1:0] mode_hold_ms;
        logic [SPEED_W-1:0] slow_threshold;
        logic [SPEED_W-1:0] sensor_gain_left;
        logic [SPEED_W-1:0] sensor_gain_right;
    } t_cfg;

    typedef struct packed {
        logic               slow;
        logic [SPEED_W-1:0] pulses;
        logic [SPEED_W-1:0] gain;
        logic [SPEED_W-1:0] elapsed;
    } t_arith_req;

    function automatic logic [SPEED_W-1:0] sat_inc(input logic [SPEED_W-1:0] v);
        sat_inc = (v == SAT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// ===== hdl/dmwsm_stream_if.sv =====
interface dmwsm_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/dual_mode_wheel_speed_meter_unit.sv =====
// Dual-mode wheel speed meter for a left and a right wheel.
// The input channel carries one word per sub-millisecond tick with a
// rising-edge flag for each wheel; TICKS_PER_MS ticks make one millisecond.
// The output channel returns exactly one word per input word: both held
// speeds, their mean, the mode of each wheel and a flag per wheel that marks
// a fresh measurement. Registers are to be written over the APB port only
// while idle; the block itself does not enforce this. Each wheel that measures
// on a tick passes through the shared serial unit, which forms pulses times
// gain one bit a cycle and then divides one quotient bit a cycle. The next
// word can be accepted in the cycle after the result has moved to the output
// register, even while that register still waits on the receiver. When the
// receiver stalls, the block holds its next result until the register frees.
// Reset clears all counters, held speeds and modes (slow mode), empties the
// output register and restores the register defaults.
module dual_mode_wheel_speed_meter_unit
    import dmwsm_pkg::*;
#(
    parameter int TICKS_PER_MS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dmwsm_stream_if.sink          i_in,
    dmwsm_stream_if.source        o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MEAS = 5'b00010,
        S_CALC = 5'b00100,
        S_MODE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state;
    logic                r_wheel;
    logic [TICK_W-1:0]   r_sub_tick;
    logic [SPEED_W-1:0]  r_pulses  [2];
    logic [SPEED_W-1:0]  r_elapsed [2];
    logic [SPEED_W-1:0]  r_age     [2];
    logic [SPEED_W-1:0]  r_speed   [2];
    logic [1:0]          r_mode;
    logic [1:0]          r_fresh;
    logic                r_out_valid;
    t_out_word           r_out;

    t_cfg                w_cfg;
    t_arith_req          w_req;
    logic                w_start;
    logic                w_done;
    logic [SPEED_W-1:0]  w_result;
    logic [SPEED_W-1:0]  w_window;
    logic                w_measure;
    logic                w_accept;
    logic                w_load;
    logic [TICK_W-1:0]   n_sub_tick;
    logic                w_ms;
    logic [SPEED_W:0]    w_sum;

    dmwsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dmwsm_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_req    (w_req),
        .o_done   (w_done),
        .o_result (w_result)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign n_sub_tick = r_sub_tick + 1'b1;
    assign w_ms       = (n_sub_tick >= TICK_W'(TICKS_PER_MS));

    assign w_window  = r_wheel ? w_cfg.window_right_ms : w_cfg.window_left_ms;
    assign w_measure = r_mode[r_wheel] ? (r_elapsed[r_wheel] >= w_window)
                                       : (r_pulses[r_wheel] != '0);

    assign w_req.slow    = !r_mode[r_wheel];
    assign w_req.pulses  = r_pulses[r_wheel];
    assign w_req.gain    = r_wheel ? w_cfg.sensor_gain_right : w_cfg.sensor_gain_left;
    assign w_req.elapsed = r_elapsed[r_wheel];
    assign w_start       = (r_state == S_MEAS) && w_measure;

    assign w_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign w_sum  = {1'b0, r_speed[0]} + {1'b0, r_speed[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= 1'b0;
            r_sub_tick  <= '0;
            r_mode      <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_pulses[i]  <= '0;
                r_elapsed[i] <= '0;
                r_age[i]     <= '0;
                r_speed[i]   <= '0;
            end
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sub_tick <= w_ms ? '0 : n_sub_tick;
                        if (w_ms) begin
                            for (int i = 0; i < 2; i++) begin
                                r_elapsed[i] <= sat_inc(r_elapsed[i]);
                                r_age[i]     <= sat_inc(r_age[i]);
                            end
                        end
                        if (i_in.data.edge_left) begin
                            r_pulses[0] <= sat_inc(r_pulses[0]);
                        end
                        if (i_in.data.edge_right) begin
                            r_pulses[1] <= sat_inc(r_pulses[1]);
                        end
                        r_fresh <= '0;
                        r_wheel <= 1'b0;
                        r_state <= S_MEAS;
                    end
                end
                S_MEAS: begin
                    r_state <= w_measure ? S_CALC : S_MODE;
                end
                S_CALC: begin
                    if (w_done) begin
                        r_speed[r_wheel]   <= w_result;
                        r_pulses[r_wheel]  <= '0;
                        r_elapsed[r_wheel] <= '0;
                        r_fresh[r_wheel]   <= 1'b1;
                        r_state            <= S_MODE;
                    end
                end
                S_MODE: begin
                    if (r_age[r_wheel] >= w_cfg.mode_hold_ms) begin
                        r_mode[r_wheel] <= (r_speed[r_wheel] > w_cfg.slow_threshold);
                        r_age[r_wheel]  <= '0;
                    end
                    if (r_wheel) begin
                        r_state <= S_OUT;
                    end else begin
                        r_wheel <= 1'b1;
                        r_state <= S_MEAS;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.speed_left  <= r_speed[0];
            r_out.speed_right <= r_speed[1];
            r_out.speed_mean  <= w_sum[SPEED_W:1];
            r_out.fast_left   <= r_mode[0];
            r_out.fast_right  <= r_mode[1];
            r_out.new_left    <= r_fresh[0];
            r_out.new_right   <= r_fresh[1];
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MEAS) && !r_wheel)
        else $error("accepted word did not start the left wheel");

    a_sub_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub_tick < TICK_W'(TICKS_PER_MS))
        else $error("sub tick count out of range");

    a_out_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && r_out_valid && !o_out.ready |=> (r_state == S_OUT))
        else $error("result overwrote a word still waiting");

endmodule

// ===== hdl/dmwsm_regs.sv =====
module dmwsm_regs
    import dmwsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg             r_cfg;
    logic [2:0]       w_index;
    logic             w_write;
    logic [SPEED_W-1:0] w_rdata;

    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;
    assign prdata  = {{(APB_DATA_W-SPEED_W){1'b0}}, w_rdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_left_ms    <= 16'd100;
            r_cfg.window_right_ms   <= 16'd500;
            r_cfg.mode_hold_ms      <= 16'd500;
            r_cfg.slow_threshold    <= 16'd10;
            r_cfg.sensor_gain_left  <= 16'd322;
            r_cfg.sensor_gain_right <= 16'd322;
        end else if (w_write) begin
            unique case (w_index)
                REG_WINDOW_LEFT:  r_cfg.window_left_ms    <= pwdata[SPEED_W-1:0];
                REG_WINDOW_RIGHT: r_cfg.window_right_ms   <= pwdata[SPEED_W-1:0];
                REG_MODE_HOLD:    r_cfg.mode_hold_ms      <= pwdata[SPEED_W-1:0];
                REG_SLOW_THRESH:  r_cfg.slow_threshold    <= pwdata[SPEED_W-1:0];
                REG_GAIN_LEFT:    r_cfg.sensor_gain_left  <= pwdata[SPEED_W-1:0];
                REG_GAIN_RIGHT:   r_cfg.sensor_gain_right <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_WINDOW_LEFT:  w_rdata = r_cfg.window_left_ms;
            REG_WINDOW_RIGHT: w_rdata = r_cfg.window_right_ms;
            REG_MODE_HOLD:    w_rdata = r_cfg.mode_hold_ms;
            REG_SLOW_THRESH:  w_rdata = r_cfg.slow_threshold;
            REG_GAIN_LEFT:    w_rdata = r_cfg.sensor_gain_left;
            REG_GAIN_RIGHT:   w_rdata = r_cfg.sensor_gain_right;
            default:          w_rdata = '0;
        endcase
    end

endmodule

// ===== hdl/dmwsm_arith.sv =====
module dmwsm_arith
    import dmwsm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_arith_req         i_req,
    output logic               o_done,
    output logic [SPEED_W-1:0] o_result
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_DONE = 4'b1000
    } t_astate;

    t_astate             r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_mcand;
    logic [SPEED_W-1:0]  r_mplier;
    logic [SPEED_W-1:0]  r_div;
    logic [SPEED_W-1:0]  r_rem;

    logic [PROD_W-1:0]   n_mcand;
    logic [SPEED_W-1:0]  n_div;
    logic [SPEED_W:0]    w_rem_sh;
    logic [SPEED_W:0]    w_diff;
    logic                w_qbit;

    // Slow mode scales the gain by ten: 8g + 2g.
    assign n_mcand = i_req.slow ? ((PROD_W'(i_req.gain) << 3) + (PROD_W'(i_req.gain) << 1))
                                : PROD_W'(i_req.gain);
    assign n_div   = !i_req.slow ? FAST_DIVISOR
                   : ((i_req.elapsed == '0) ? 16'd1 : i_req.elapsed);

    assign w_rem_sh = {r_rem, r_acc[PROD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_div};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_div});

    assign o_done   = (r_state == A_DONE);
    assign o_result = (|r_acc[PROD_W-1:SPEED_W]) ? SAT_MAX : r_acc[SPEED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_state  <= A_MUL;
                        r_cnt    <= '0;
                        r_acc    <= '0;
                        r_mcand  <= n_mcand;
                        r_mplier <= i_req.pulses;
                        r_div    <= n_div;
                    end
                end
                A_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_state <= A_DIV;
                        r_cnt   <= '0;
                        r_rem   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                A_DIV: begin
                    r_rem <= w_qbit ? w_diff[SPEED_W-1:0] : w_rem_sh[SPEED_W-1:0];
                    r_acc <= {r_acc[PROD_W-2:0], w_qbit};
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= A_DONE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                A_DONE: begin
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == A_IDLE))
        else $error("arith start while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("arith done longer than one cycle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(DIV_STEPS))
        else $error("arith step counter out of range");

endmodule

// ===== sim/tb_dual_mode_wheel_speed_meter_unit.sv =====
`timescale 1ns / 100ps

module tb_dual_mode_wheel_speed_meter_unit;
    import dmwsm_pkg::*;

    localparam int TICKS_PER_MS    = 10;
    localparam int DIR_N           = 28;
    localparam int PHASES          = 8;
    localparam int PHASE_WORDS     = 110;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 150;
    localparam int REPORT_CAP      = 40;

    localparam logic [2:0] REG_UNUSED_6 = 3'd6;
    localparam logic [2:0] REG_UNUSED_7 = 3'd7;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [2:0] reg_idx;
        logic [15:0] value;
        t_in_word   edges;
        logic       typed;
        t_out_word  want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    dmwsm_stream_if #(.t_payload(t_in_word))  in_ch ();
    dmwsm_stream_if #(.t_payload(t_out_word)) out_ch ();

    dual_mode_wheel_speed_meter_unit #(
        .TICKS_PER_MS(TICKS_PER_MS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Index 0 is the left wheel, index 1 the right wheel.
    logic [3:0]  sub_tick = '0;
    logic [15:0] cnt_pulses [2] = '{16'd0, 16'd0};
    logic [15:0] cnt_elapsed [2] = '{16'd0, 16'd0};
    logic [15:0] cnt_age [2] = '{16'd0, 16'd0};
    logic [15:0] held_speed [2] = '{16'd0, 16'd0};
    logic        fast_mode [2] = '{1'b0, 1'b0};
    logic [15:0] cfg_window [2] = '{16'd100, 16'd500};
    logic [15:0] cfg_gain [2] = '{16'd322, 16'd322};
    logic [15:0] cfg_hold = 16'd500;
    logic [15:0] cfg_thresh = 16'd10;

    t_out_word pending_readings [$];
    int unsigned n_mismatch = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_off_req = 1'b0;

    t_dir_row directed_rows [DIR_N] = '{
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b0, 1'b0}, 1'b1,
          '{16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b0}, 1'b1,
          '{16'd3220, 16'd0, 16'd1610, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b0, 1'b1}, 1'b1,
          '{16'd3220, 16'd3220, 16'd3220, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b1}, 1'b1,
          '{16'd3220, 16'd3220, 16'd3220, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{ROW_WRITE, REG_GAIN_LEFT,    16'hFFFF,  '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_MODE_HOLD,    16'd0,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_SLOW_THRESH,  16'd0,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b0}, 1'b1,
          '{16'hFFFF, 16'd3220, 16'd34377, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{ROW_WRITE, REG_WINDOW_LEFT,  16'd0,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b1}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_UNUSED_6,     16'd7,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_UNUSED_7,     16'd9,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b0, 1'b1}, 1'b0, '0},
        '{ROW_WRITE, REG_SLOW_THRESH,  16'hFFFF,  '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b1}, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_LEFT,    16'd0,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN_RIGHT,   16'hFFFF,  '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b1}, 1'b0, '0},
        '{ROW_WRITE, REG_WINDOW_RIGHT, 16'hFFFF,  '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_MODE_HOLD,    16'hFFFF,  '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b1}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b1, 1'b0}, 1'b0, '0},
        '{ROW_WRITE, REG_WINDOW_LEFT,  16'hFFFF,  '{1'b0, 1'b0}, 1'b0, '0},
        '{ROW_TICK,  REG_WINDOW_LEFT,  16'd0,     '{1'b0, 1'b1}, 1'b0, '0}
    };

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] clip_speed(input logic [63:0] v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic measure_wheel(input int s);
        logic fresh;
        logic [63:0] span;
        fresh = 1'b0;
        if (fast_mode[s]) begin
            if (cnt_elapsed[s] >= cfg_window[s]) begin
                held_speed[s] = clip_speed(64'(cnt_pulses[s]) * 64'(cfg_gain[s]) / 64'd100);
                cnt_pulses[s] = '0;
                cnt_elapsed[s] = '0;
                fresh = 1'b1;
            end
        end else if (cnt_pulses[s] != 16'd0) begin
            span = (cnt_elapsed[s] == 16'd0) ? 64'd1 : 64'(cnt_elapsed[s]);
            held_speed[s] = clip_speed(64'd10 * 64'(cfg_gain[s]) * 64'(cnt_pulses[s]) / span);
            cnt_pulses[s] = '0;
            cnt_elapsed[s] = '0;
            fresh = 1'b1;
        end
        if (cnt_age[s] >= cfg_hold) begin
            fast_mode[s] = held_speed[s] > cfg_thresh;
            cnt_age[s] = '0;
        end
        return fresh;
    endfunction

    function automatic t_out_word advance_tick(input t_in_word w);
        t_out_word r;
        logic [16:0] sum;
        sub_tick = sub_tick + 4'd1;
        if (sub_tick >= TICKS_PER_MS) begin
            sub_tick = '0;
            for (int s = 0; s < 2; s++) begin
                cnt_elapsed[s] = bump16(cnt_elapsed[s]);
                cnt_age[s] = bump16(cnt_age[s]);
            end
        end
        if (w.edge_left) cnt_pulses[0] = bump16(cnt_pulses[0]);
        if (w.edge_right) cnt_pulses[1] = bump16(cnt_pulses[1]);
        r.new_left = measure_wheel(0);
        r.new_right = measure_wheel(1);
        sum = {1'b0, held_speed[0]} + {1'b0, held_speed[1]};
        r.speed_left = held_speed[0];
        r.speed_right = held_speed[1];
        r.speed_mean = sum[16:1];
        r.fast_left = fast_mode[0];
        r.fast_right = fast_mode[1];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        n_mismatch++;
        if (n_mismatch <= REPORT_CAP) begin
            $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : check_out
        t_out_word want;
        t_out_word got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_readings.size() == 0) begin
                report_mismatch("count of words with no reading pending", 1, 0);
            end else begin
                want = pending_readings.pop_front();
                if (got.speed_left != want.speed_left)
                    report_mismatch("speed_left", got.speed_left, want.speed_left);
                if (got.speed_right != want.speed_right)
                    report_mismatch("speed_right", got.speed_right, want.speed_right);
                if (got.speed_mean != want.speed_mean)
                    report_mismatch("speed_mean", got.speed_mean, want.speed_mean);
                if (got.fast_left !== want.fast_left)
                    report_mismatch("fast_left", got.fast_left, want.fast_left);
                if (got.fast_right !== want.fast_right)
                    report_mismatch("fast_right", got.fast_right, want.fast_right);
                if (got.new_left !== want.new_left)
                    report_mismatch("new_left", got.new_left, want.new_left);
                if (got.new_right !== want.new_right)
                    report_mismatch("new_right", got.new_right, want.new_right);
            end
        end
    end

    task automatic send_tick(input t_in_word w, input logic typed, input t_out_word typed_want);
        t_out_word predicted;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = advance_tick(w);
        pending_readings.push_back(typed ? typed_want : predicted);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_WINDOW_LEFT:  cfg_window[0] = val;
            REG_WINDOW_RIGHT: cfg_window[1] = val;
            REG_MODE_HOLD:    cfg_hold = val;
            REG_SLOW_THRESH:  cfg_thresh = val;
            REG_GAIN_LEFT:    cfg_gain[0] = val;
            REG_GAIN_RIGHT:   cfg_gain[1] = val;
            default: ;
        endcase
        if (idx == REG_UNUSED_6 || idx == REG_UNUSED_7) begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end else begin
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            if (prdata !== {16'd0, val})
                report_mismatch("register read back", prdata, val);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    function automatic logic [15:0] pick_span(input int unsigned top);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, top));
        endcase
    endfunction

    function automatic logic [15:0] pick_wide(input int unsigned top);
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("dual_mode_wheel_speed_meter_unit test failed");
        $finish;
    end

    initial begin
        int unsigned dens_l;
        int unsigned dens_r;
        t_in_word w;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                reg_write(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_tick(directed_rows[i].edges, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            if (p == 0) begin
                reg_write(REG_WINDOW_LEFT, 16'd1);
                reg_write(REG_WINDOW_RIGHT, 16'd3);
                reg_write(REG_MODE_HOLD, 16'd1);
                reg_write(REG_SLOW_THRESH, 16'd500);
                reg_write(REG_GAIN_LEFT, 16'd322);
                reg_write(REG_GAIN_RIGHT, 16'hFFFF);
            end else begin
                reg_write(REG_WINDOW_LEFT, pick_span(12));
                reg_write(REG_WINDOW_RIGHT, pick_span(12));
                reg_write(REG_MODE_HOLD, pick_span(8));
                reg_write(REG_SLOW_THRESH, pick_wide(4000));
                reg_write(REG_GAIN_LEFT, pick_wide(65535));
                reg_write(REG_GAIN_RIGHT, pick_wide(65535));
            end
            dens_l = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(0, 100);
            dens_r = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 100);
            tx_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 3 && k == 20) hold_off_req = 1'b1;
                w.edge_left = $urandom_range(0, 99) < dens_l;
                w.edge_right = $urandom_range(0, 99) < dens_r;
                send_tick(w, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("dual_mode_wheel_speed_meter_unit test passed");
        end else begin
            $display("dual_mode_wheel_speed_meter_unit test failed");
        end
        $finish;
    end

endmodule
